// ----- sv/qra_pkg.sv -----
`timescale 1ns / 1ps
// Package for the quaternion rotation accumulator.
// Widths, state codes, queue entry type and small helper functions.
// Depends on nothing.
package qra_pkg;

    localparam int ELEM_WIDTH   = 16;
    localparam int STORE_W      = (ELEM_WIDTH > 16) ? ELEM_WIDTH : 16;
    localparam int ANGLE_W      = 16;
    localparam int AXIS_W       = 16;
    localparam int OUT_W        = 16;
    localparam int ROW_W        = 2;

    localparam int CW           = 18;
    localparam int SC_W         = 17;
    localparam int STEP_W       = 4;
    localparam int CORDIC_LAST  = 14;
    localparam int Q_W          = 18;
    localparam int P_W          = 32;
    localparam int NUM_PROD     = 10;
    localparam int MUL_LAST     = 12;
    localparam int NUM_ELEM     = 9;
    localparam int T_W          = 33;
    localparam int N2_W         = 32;
    localparam int FRAC         = 14;
    localparam int QUO_W        = 17;
    localparam int D_W          = 48;
    localparam int REM_W        = N2_W + 2;
    localparam int BIT_W        = 5;
    localparam int RM_W         = 18;
    localparam int ACC_W        = RM_W + STORE_W + 2;

    localparam logic signed [CW-1:0]    CORDIC_X0 = CW'(9949);
    localparam logic signed [CW-1:0]    UNIT_POS  = CW'(16384);
    localparam logic signed [CW-1:0]    UNIT_NEG  = -CW'(16384);
    localparam logic signed [RM_W-1:0]  ONE_RM    = RM_W'(16384);
    localparam logic signed [ACC_W-1:0] ROUND_ACC = ACC_W'(8192);
    localparam logic signed [ACC_W-1:0] SAT_HI    =
        ACC_W'((longint'(1) <<< (ELEM_WIDTH - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] SAT_LO    = -SAT_HI - ACC_W'(1);
    localparam logic [STORE_W-1:0]      ONE_ELEM  = STORE_W'(16384);

    typedef enum logic [2:0] {
        F_IDLE,
        F_CORDIC,
        F_SINCOS,
        F_MUL,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV_LD,
        B_DIV,
        B_DIV_WR,
        B_MUL_P,
        B_MUL_A,
        B_MUL_W,
        B_COMMIT,
        B_EMIT
    } t_back_state;

    typedef struct packed {
        logic [NUM_ELEM-1:0][T_W-1:0] t;
        logic [N2_W-1:0]              n2;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef logic [2:0][STORE_W-1:0] t_row;

    function automatic logic [14:0] atan_unit(input logic [STEP_W-1:0] i);
        logic [14:0] v;
        case (i)
            4'd0:    v = 15'd16384;
            4'd1:    v = 15'd9672;
            4'd2:    v = 15'd5110;
            4'd3:    v = 15'd2594;
            4'd4:    v = 15'd1302;
            4'd5:    v = 15'd652;
            4'd6:    v = 15'd326;
            4'd7:    v = 15'd163;
            4'd8:    v = 15'd81;
            4'd9:    v = 15'd41;
            4'd10:   v = 15'd20;
            4'd11:   v = 15'd10;
            4'd12:   v = 15'd5;
            4'd13:   v = 15'd3;
            4'd14:   v = 15'd1;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [SC_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [SC_W-1:0] r;
        if (v > UNIT_POS) begin
            r = SC_W'(16384);
        end else if (v < UNIT_NEG) begin
            r = -SC_W'(16384);
        end else begin
            r = v[SC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/qra_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces: input item and output row, valid/ready handshake.
// Depends on qra_pkg.
interface qra_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [qra_pkg::ANGLE_W-1:0]          angle;
    logic signed [qra_pkg::AXIS_W-1:0]    axis_x;
    logic signed [qra_pkg::AXIS_W-1:0]    axis_y;
    logic signed [qra_pkg::AXIS_W-1:0]    axis_z;

    modport source (output valid, angle, axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, angle, axis_x, axis_y, axis_z, output ready);
endinterface

interface qra_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [qra_pkg::ROW_W-1:0]            row_index;
    logic signed [qra_pkg::OUT_W-1:0]     col0;
    logic signed [qra_pkg::OUT_W-1:0]     col1;
    logic signed [qra_pkg::OUT_W-1:0]     col2;
    logic                                 last_row;

    modport source (output valid, row_index, col0, col1, col2, last_row, input ready);
    modport sink   (input valid, row_index, col0, col1, col2, last_row, output ready);
endinterface

// ----- sv/qra_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts a transaction, runs CORDIC sin/cos, forms the quaternion
// and its product terms, and pushes a job to the queue. Depends on qra_pkg, qra_if.
module qra_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    qra_in_if.sink                 i_in,
    output logic                   o_push,
    output qra_pkg::t_job          o_job,
    input  qra_pkg::t_q_status     i_status
);

    qra_pkg::t_front_state r_state, n_state;

    logic signed [qra_pkg::AXIS_W-1:0] r_ax, r_ay, r_az;
    logic                              r_swap;
    logic signed [qra_pkg::CW-1:0]     r_x, r_y, r_z;
    logic [qra_pkg::STEP_W-1:0]        r_step;
    logic signed [qra_pkg::SC_W-1:0]   r_s, r_qw;
    logic signed [qra_pkg::Q_W-1:0]    r_qx, r_qy, r_qz;
    logic signed [qra_pkg::P_W-1:0]    r_p [qra_pkg::NUM_PROD];
    logic [qra_pkg::STEP_W-1:0]        r_cnt;

    logic signed [qra_pkg::CW-1:0]     c_dx, c_dy, c_at;
    logic signed [qra_pkg::SC_W-1:0]   c_cx, c_cy;
    logic signed [qra_pkg::Q_W-1:0]    c_a, c_b;
    logic signed [2*qra_pkg::Q_W-1:0]  c_prod, c_shift;
    logic [qra_pkg::STEP_W-1:0]        c_pidx;
    logic signed [qra_pkg::T_W-1:0]    c_e [qra_pkg::NUM_PROD];
    logic                              c_accept;

    assign i_in.ready = (r_state == qra_pkg::F_IDLE);
    assign c_accept   = i_in.valid && i_in.ready;
    assign o_push     = (r_state == qra_pkg::F_PUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qra_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qra_pkg::F_IDLE: begin
                if (c_accept) n_state = qra_pkg::F_CORDIC;
            end
            qra_pkg::F_CORDIC: begin
                if (r_step == qra_pkg::STEP_W'(qra_pkg::CORDIC_LAST)) n_state = qra_pkg::F_SINCOS;
            end
            qra_pkg::F_SINCOS: n_state = qra_pkg::F_MUL;
            qra_pkg::F_MUL: begin
                if (r_cnt == qra_pkg::STEP_W'(qra_pkg::MUL_LAST)) n_state = qra_pkg::F_PUSH;
            end
            qra_pkg::F_PUSH: begin
                if (!i_status.full) n_state = qra_pkg::F_IDLE;
            end
            default: n_state = qra_pkg::F_IDLE;
        endcase
    end

    // CORDIC rotation step
    assign c_dx = r_y >>> r_step;
    assign c_dy = r_x >>> r_step;
    assign c_at = signed'(qra_pkg::CW'(qra_pkg::atan_unit(r_step)));
    assign c_cx = qra_pkg::clamp_unit(r_x);
    assign c_cy = qra_pkg::clamp_unit(r_y);

    // shared multiplier: axis scaling, then the ten quaternion products
    always_comb begin
        case (r_cnt)
            4'd0:    begin c_a = qra_pkg::Q_W'(r_ax); c_b = qra_pkg::Q_W'(r_s);  end
            4'd1:    begin c_a = qra_pkg::Q_W'(r_ay); c_b = qra_pkg::Q_W'(r_s);  end
            4'd2:    begin c_a = qra_pkg::Q_W'(r_az); c_b = qra_pkg::Q_W'(r_s);  end
            4'd3:    begin c_a = r_qx;                c_b = r_qx;                end
            4'd4:    begin c_a = r_qy;                c_b = r_qy;                end
            4'd5:    begin c_a = r_qz;                c_b = r_qz;                end
            4'd6:    begin c_a = qra_pkg::Q_W'(r_qw); c_b = qra_pkg::Q_W'(r_qw); end
            4'd7:    begin c_a = r_qx;                c_b = r_qy;                end
            4'd8:    begin c_a = r_qx;                c_b = r_qz;                end
            4'd9:    begin c_a = r_qy;                c_b = r_qz;                end
            4'd10:   begin c_a = r_qx;                c_b = qra_pkg::Q_W'(r_qw); end
            4'd11:   begin c_a = r_qy;                c_b = qra_pkg::Q_W'(r_qw); end
            4'd12:   begin c_a = r_qz;                c_b = qra_pkg::Q_W'(r_qw); end
            default: begin c_a = '0;                  c_b = '0;                  end
        endcase
    end

    assign c_prod  = c_a * c_b;
    assign c_shift = c_prod >>> qra_pkg::FRAC;
    assign c_pidx  = r_cnt - 4'd3;

    always_ff @(posedge i_clk) begin
        case (r_state)
            qra_pkg::F_IDLE: begin
                if (c_accept) begin
                    r_ax   <= i_in.axis_x;
                    r_ay   <= i_in.axis_y;
                    r_az   <= i_in.axis_z;
                    r_swap <= i_in.angle[qra_pkg::ANGLE_W-1];
                    r_x    <= qra_pkg::CORDIC_X0;
                    r_y    <= '0;
                    r_z    <= signed'(qra_pkg::CW'(i_in.angle[qra_pkg::ANGLE_W-2:0]));
                    r_step <= '0;
                end
            end
            qra_pkg::F_CORDIC: begin
                if (!r_z[qra_pkg::CW-1]) begin
                    r_x <= r_x - c_dx;
                    r_y <= r_y + c_dy;
                    r_z <= r_z - c_at;
                end else begin
                    r_x <= r_x + c_dx;
                    r_y <= r_y - c_dy;
                    r_z <= r_z + c_at;
                end
                r_step <= r_step + 4'd1;
            end
            qra_pkg::F_SINCOS: begin
                r_s   <= r_swap ? c_cx : c_cy;
                r_qw  <= r_swap ? -c_cy : c_cx;
                r_cnt <= '0;
            end
            qra_pkg::F_MUL: begin
                case (r_cnt)
                    4'd0:    r_qx <= c_shift[qra_pkg::Q_W-1:0];
                    4'd1:    r_qy <= c_shift[qra_pkg::Q_W-1:0];
                    4'd2:    r_qz <= c_shift[qra_pkg::Q_W-1:0];
                    default: r_p[c_pidx] <= c_prod[qra_pkg::P_W-1:0];
                endcase
                r_cnt <= r_cnt + 4'd1;
            end
            default: begin
            end
        endcase
    end

    // p: xx yy zz ww xy xz yz xw yw zw
    always_comb begin
        for (int k = 0; k < qra_pkg::NUM_PROD; k++) begin
            c_e[k] = qra_pkg::T_W'(r_p[k]);
        end
        o_job.t[0] = c_e[1] + c_e[2];
        o_job.t[1] = c_e[4] + c_e[9];
        o_job.t[2] = c_e[5] - c_e[8];
        o_job.t[3] = c_e[4] - c_e[9];
        o_job.t[4] = c_e[0] + c_e[2];
        o_job.t[5] = c_e[6] + c_e[7];
        o_job.t[6] = c_e[5] + c_e[8];
        o_job.t[7] = c_e[6] - c_e[7];
        o_job.t[8] = c_e[0] + c_e[1];
        o_job.n2   = r_p[0][qra_pkg::N2_W-1:0] + r_p[1][qra_pkg::N2_W-1:0]
                   + r_p[2][qra_pkg::N2_W-1:0] + r_p[3][qra_pkg::N2_W-1:0];
    end

endmodule

// ----- sv/qra_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between front and back end.
// Depends on qra_pkg.
module qra_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  qra_pkg::t_job         i_job,
    input  logic                  i_pop,
    output qra_pkg::t_job         o_job,
    output qra_pkg::t_q_status    o_status
);

    qra_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          c_wr, c_rd;

    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);
    assign c_wr  = i_push && !o_status.full;
    assign c_rd  = i_pop && !o_status.empty;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_wr) r_wp <= ~r_wp;
            if (c_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, c_wr} - {1'b0, c_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr) r_mem[r_wp] <= i_job;
    end

endmodule

// ----- sv/qra_back.sv -----
`timescale 1ns / 1ps
// Back end: bit-serial rounding divider builds R, sequential 3x3 multiply
// R*S with saturation, and row output register. Depends on qra_pkg, qra_if.
module qra_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qra_pkg::t_job         i_job,
    input  qra_pkg::t_q_status    i_status,
    output logic                  o_pop,
    qra_out_if.source             o_out
);

    qra_pkg::t_back_state r_state, n_state;

    logic signed [qra_pkg::T_W-1:0]           r_t [qra_pkg::NUM_ELEM];
    logic [qra_pkg::N2_W-1:0]                 r_n2;
    logic [3:0]                               r_k;
    logic [qra_pkg::REM_W-1:0]                r_rem;
    logic [qra_pkg::QUO_W-1:0]                r_dlo, r_quo;
    logic [qra_pkg::BIT_W-1:0]                r_bit;
    logic                                     r_neg;
    logic signed [qra_pkg::RM_W-1:0]          r_rm [qra_pkg::NUM_ELEM];
    qra_pkg::t_row                            r_s [3];
    qra_pkg::t_row                            r_nm [3];
    logic [1:0]                               r_i, r_j, r_kk, r_row;
    logic signed [qra_pkg::RM_W+qra_pkg::STORE_W-1:0] r_prod;
    logic signed [qra_pkg::ACC_W-1:0]         r_acc;

    logic                                     r_ovalid;
    logic [qra_pkg::ROW_W-1:0]                r_orow;
    logic [qra_pkg::OUT_W-1:0]                r_oc0, r_oc1, r_oc2;
    logic                                     r_olast;

    logic signed [qra_pkg::T_W-1:0]           c_tk;
    logic [qra_pkg::T_W-1:0]                  c_mag;
    logic [qra_pkg::D_W-1:0]                  c_d;
    logic [qra_pkg::REM_W-1:0]                c_trial;
    logic                                     c_ge;
    logic signed [qra_pkg::RM_W-1:0]          c_v, c_rmv;
    logic [3:0]                               c_ridx;
    logic signed [qra_pkg::RM_W-1:0]          c_rm_sel;
    logic signed [qra_pkg::STORE_W-1:0]       c_s_sel;
    logic signed [qra_pkg::ACC_W-1:0]         c_pext, c_acc_base, c_rnd;
    logic [qra_pkg::STORE_W-1:0]              c_sat;
    logic                                     c_load;

    assign o_pop  = (r_state == qra_pkg::B_IDLE) && !i_status.empty;
    assign c_load = (r_state == qra_pkg::B_EMIT) && (!r_ovalid || o_out.ready);

    assign o_out.valid     = r_ovalid;
    assign o_out.row_index = r_orow;
    assign o_out.col0      = r_oc0;
    assign o_out.col1      = r_oc1;
    assign o_out.col2      = r_oc2;
    assign o_out.last_row  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qra_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qra_pkg::B_IDLE: begin
                if (!i_status.empty) begin
                    n_state = (i_job.n2 == '0) ? qra_pkg::B_EMIT : qra_pkg::B_DIV_LD;
                end
            end
            qra_pkg::B_DIV_LD: n_state = qra_pkg::B_DIV;
            qra_pkg::B_DIV: begin
                if (r_bit == '0) n_state = qra_pkg::B_DIV_WR;
            end
            qra_pkg::B_DIV_WR: begin
                n_state = (r_k == 4'd8) ? qra_pkg::B_MUL_P : qra_pkg::B_DIV_LD;
            end
            qra_pkg::B_MUL_P: n_state = qra_pkg::B_MUL_A;
            qra_pkg::B_MUL_A: begin
                n_state = (r_kk == 2'd2) ? qra_pkg::B_MUL_W : qra_pkg::B_MUL_P;
            end
            qra_pkg::B_MUL_W: begin
                n_state = (r_i == 2'd2 && r_j == 2'd2) ? qra_pkg::B_COMMIT : qra_pkg::B_MUL_P;
            end
            qra_pkg::B_COMMIT: n_state = qra_pkg::B_EMIT;
            qra_pkg::B_EMIT: begin
                if (c_load && r_row == 2'd2) n_state = qra_pkg::B_IDLE;
            end
            default: n_state = qra_pkg::B_IDLE;
        endcase
    end

    // divider: q = (|t|*32768 + n2/2) / n2, quotient fits 17 bits
    assign c_tk    = r_t[r_k];
    assign c_mag   = c_tk[qra_pkg::T_W-1] ? -c_tk : c_tk;
    assign c_d     = qra_pkg::D_W'({c_mag[qra_pkg::T_W-2:0], 15'b0})
                   + qra_pkg::D_W'(r_n2 >> 1);
    assign c_trial = {r_rem[qra_pkg::REM_W-2:0], r_dlo[qra_pkg::QUO_W-1]};
    assign c_ge    = (c_trial >= qra_pkg::REM_W'(r_n2));
    assign c_v     = r_neg ? -signed'(qra_pkg::RM_W'(r_quo)) : signed'(qra_pkg::RM_W'(r_quo));
    assign c_rmv   = (r_k == 4'd0 || r_k == 4'd4 || r_k == 4'd8) ? (qra_pkg::ONE_RM - c_v) : c_v;

    // multiply-accumulate over k
    assign c_ridx     = 4'(r_i) * 4'd3 + 4'(r_kk);
    assign c_rm_sel   = r_rm[c_ridx];
    assign c_s_sel    = signed'(r_s[r_kk][r_j]);
    assign c_pext     = qra_pkg::ACC_W'(r_prod);
    assign c_acc_base = (r_kk == 2'd0) ? '0 : r_acc;
    assign c_rnd      = (r_acc + qra_pkg::ROUND_ACC) >>> qra_pkg::FRAC;

    always_comb begin
        if (c_rnd > qra_pkg::SAT_HI) begin
            c_sat = qra_pkg::SAT_HI[qra_pkg::STORE_W-1:0];
        end else if (c_rnd < qra_pkg::SAT_LO) begin
            c_sat = qra_pkg::SAT_LO[qra_pkg::STORE_W-1:0];
        end else begin
            c_sat = c_rnd[qra_pkg::STORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            qra_pkg::B_IDLE: begin
                if (!i_status.empty) begin
                    for (int k = 0; k < qra_pkg::NUM_ELEM; k++) begin
                        r_t[k] <= signed'(i_job.t[k]);
                    end
                    r_n2  <= i_job.n2;
                    r_k   <= '0;
                    r_row <= '0;
                end
            end
            qra_pkg::B_DIV_LD: begin
                r_neg <= c_tk[qra_pkg::T_W-1];
                r_rem <= qra_pkg::REM_W'(c_d[qra_pkg::D_W-1:qra_pkg::QUO_W]);
                r_dlo <= c_d[qra_pkg::QUO_W-1:0];
                r_quo <= '0;
                r_bit <= qra_pkg::BIT_W'(qra_pkg::QUO_W - 1);
            end
            qra_pkg::B_DIV: begin
                r_rem <= c_ge ? (c_trial - qra_pkg::REM_W'(r_n2)) : c_trial;
                r_dlo <= {r_dlo[qra_pkg::QUO_W-2:0], 1'b0};
                r_quo <= {r_quo[qra_pkg::QUO_W-2:0], c_ge};
                r_bit <= r_bit - qra_pkg::BIT_W'(1);
            end
            qra_pkg::B_DIV_WR: begin
                r_rm[r_k] <= c_rmv;
                r_k       <= r_k + 4'd1;
                r_i       <= '0;
                r_j       <= '0;
                r_kk      <= '0;
            end
            qra_pkg::B_MUL_P: begin
                r_prod <= c_rm_sel * c_s_sel;
            end
            qra_pkg::B_MUL_A: begin
                r_acc <= c_acc_base + c_pext;
                if (r_kk != 2'd2) r_kk <= r_kk + 2'd1;
            end
            qra_pkg::B_MUL_W: begin
                r_nm[r_i][r_j] <= c_sat;
                r_kk           <= '0;
                if (r_j == 2'd2) begin
                    r_j <= '0;
                    r_i <= r_i + 2'd1;
                end else begin
                    r_j <= r_j + 2'd1;
                end
            end
            qra_pkg::B_COMMIT: begin
                r_row <= '0;
            end
            qra_pkg::B_EMIT: begin
                if (c_load) r_row <= r_row + 2'd1;
            end
            default: begin
            end
        endcase
    end

    // accumulated matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s[r][c] <= (r == c) ? qra_pkg::ONE_ELEM : '0;
                end
            end
        end else if (r_state == qra_pkg::B_COMMIT) begin
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= r_nm[r];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (c_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_orow  <= r_row;
            r_oc0   <= r_s[r_row][0][qra_pkg::OUT_W-1:0];
            r_oc1   <= r_s[r_row][1][qra_pkg::OUT_W-1:0];
            r_oc2   <= r_s[r_row][2][qra_pkg::OUT_W-1:0];
            r_olast <= (r_row == 2'd2);
        end
    end

endmodule

// ----- sv/quaternion_rotation_accumulator.sv -----
`timescale 1ns / 1ps
// Top level of the quaternion rotation accumulator: front end, job queue, back end.
// Depends on qra_pkg, qra_if, qra_front, qra_fifo, qra_back.
//
//   channel   dir   transaction                      per item
//   i_in      in    angle, axis_x, axis_y, axis_z    1
//   o_out     out   row_index, col0..col2, last_row  3
//
// Front end: 15 CORDIC steps and 13 passes of one multiplier per item; it takes no new item until its job is pushed.
// Back end: the bit-serial divider (9 quotients of 17 bits) and the single 3x3 MAC;
// a zero-length quaternion skips both.
// Both ends overlap through a two-entry queue; rows leave through an output register.
// Reset is synchronous, active low, and restores the identity matrix.
module quaternion_rotation_accumulator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qra_in_if.sink    i_in,
    qra_out_if.source o_out
);

    logic                 c_push, c_pop;
    qra_pkg::t_job        c_job_in, c_job_out;
    qra_pkg::t_q_status   c_status;

    qra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_push   (c_push),
        .o_job    (c_job_in),
        .i_status (c_status)
    );

    qra_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (c_push),
        .i_job    (c_job_in),
        .i_pop    (c_pop),
        .o_job    (c_job_out),
        .o_status (c_status)
    );

    qra_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (c_job_out),
        .i_status (c_status),
        .o_pop    (c_pop),
        .o_out    (o_out)
    );

endmodule

// ----- sv/qra_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the output channel of the accumulator, and its bind.
// Depends on qra_pkg and quaternion_rotation_accumulator.
module qra_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [qra_pkg::ROW_W-1:0]  i_row_index,
    input logic                       i_last_row
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("output transaction dropped while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last_row == (i_row_index == 2'd2)) && (i_row_index != 2'd3))
        else $error("last_row does not match row index");

    a_row1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && i_row_index == 2'd0) |=> (i_valid && i_row_index == 2'd1))
        else $error("row 1 does not follow row 0");

    a_row2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && i_row_index == 2'd1) |=> (i_valid && i_row_index == 2'd2))
        else $error("row 2 does not follow row 1");

endmodule

bind quaternion_rotation_accumulator qra_checker u_qra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_row_index (o_out.row_index),
    .i_last_row  (o_out.last_row)
);
